/* rtl/linear_probe_hash_table_top_macros.svh */
// Assertion macros for the linear probe hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPHT_ASSERT(lbl, prop, msg)
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/lpht_pkg.sv */
// Shared constants, types and helpers of the linear probe hash table.
package lpht_pkg;

	localparam int TABLE_SLOTS = 26;
	localparam int KEY_BYTES   = 8;
	localparam int VALUE_WIDTH = 32;

	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int KEY_W       = 8 * KEY_BYTES;
	localparam int IN_KEY_W    = 64;
	localparam int IN_VALUE_W  = 32;
	localparam int OUT_SLOT_W  = 5;
	localparam int STATUS_W    = 3;
	localparam int S_TDATA_W   = ((IN_KEY_W + IN_VALUE_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((OUT_SLOT_W + IN_VALUE_W + 7) / 8) * 8;

	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_Z = 8'h7a;

	typedef enum logic [STATUS_W-1:0] {
		ST_NEW     = 3'd0,
		ST_UPDATED = 3'd1,
		ST_FOUND   = 3'd2,
		ST_MISS    = 3'd3,
		ST_BADKEY  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_PROBE,
		S_DONE
	} state_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_SEARCH = 1'b1
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]       key;
		logic [VALUE_WIDTH-1:0] value;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		entry_t            entry;
	} wr_req_t;

	function automatic logic [VALUE_WIDTH-1:0] narrow_value(input logic [IN_VALUE_W-1:0] v);
		logic [63:0] e;
		e = 64'(signed'(v));
		return e[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [IN_VALUE_W-1:0] widen_value(input logic [VALUE_WIDTH-1:0] v);
		logic [63:0] e;
		e = 64'(signed'(v));
		return e[IN_VALUE_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

/* rtl/linear_probe_hash_table_top.sv */
// Top level of the linear probe hash table: request control, probing and result register.
//
// channel  dir  tdata (low bit up)                    tuser
// s_       in   key[63:0], value[95:64]               req_type (0 insert, 1 search)
// m_       out  slot[4:0], found_value[36:5], zeros   status[2:0]
//
// A request passes through accept, first read, a probe of each slot in turn
// (up to 26, one read of the slot memory per cycle), and a result cycle.
// A bad key skips probing and goes straight from accept to the result cycle.
// Reset clears all valid bits at once; no clearing pass.
// A result waiting on m_tready holds the block in its result cycle.
`include "linear_probe_hash_table_top_macros.svh"
module linear_probe_hash_table_top
	import lpht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // key[63:0], value[95:64]
	input  logic                 s_tuser,  // req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // slot[4:0], found_value[36:5]
	output logic [STATUS_W-1:0]  m_tuser   // status
);

	state_t                 state_q, state_d;
	req_t                   req_q;
	logic [KEY_W-1:0]       key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [SLOT_W-1:0]      idx_q;
	logic [SLOT_W-1:0]      chk_idx_s1;
	logic [SLOT_W-1:0]      cnt_q;
	status_t                res_status_q;
	logic [OUT_SLOT_W-1:0]  res_slot_q;
	logic [IN_VALUE_W-1:0]  res_fval_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;
	logic [STATUS_W-1:0]    m_tuser_q;

	logic                   rd_en;
	logic [SLOT_W-1:0]      rd_addr;
	entry_t                 rd_entry;
	logic                   rd_valid;
	wr_req_t                wr;

	logic [KEY_W-1:0]       in_key;
	logic [7:0]             in_first;
	logic                   in_bad;
	logic [SLOT_W-1:0]      in_home;
	logic                   accept;
	logic                   hit_empty;
	logic                   hit_match;
	logic                   probe_last;
	logic                   probe_done;
	logic                   out_free;
	status_t                probe_status;
	logic [IN_VALUE_W-1:0]  probe_fval;
	logic [OUT_SLOT_W-1:0]  probe_slot;

	lpht_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid),
		.wr       (wr)
	);

	assign in_key   = s_tdata[IN_KEY_W-1 -: KEY_W];
	assign in_first = s_tdata[IN_KEY_W-1 -: 8];
	assign in_bad   = !(in_first inside {[CHAR_A:CHAR_Z]});
	assign in_home  = SLOT_W'(in_first - CHAR_A);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign hit_empty  = !rd_valid;
	assign hit_match  = rd_valid && (rd_entry.key == key_q);
	assign probe_last = (cnt_q == SLOT_W'(TABLE_SLOTS - 1));
	assign probe_done = hit_empty || hit_match || probe_last;

	always_comb begin
		probe_status = ST_MISS;
		probe_slot   = '0;
		probe_fval   = '0;
		if (hit_empty) begin
			if (req_q == REQ_INSERT) begin
				probe_status = ST_NEW;
				probe_slot   = OUT_SLOT_W'(chk_idx_s1);
				probe_fval   = widen_value(val_q);
			end
		end else if (hit_match) begin
			probe_slot = OUT_SLOT_W'(chk_idx_s1);
			if (req_q == REQ_INSERT) begin
				probe_status = ST_UPDATED;
				probe_fval   = widen_value(val_q);
			end else begin
				probe_status = ST_FOUND;
				probe_fval   = widen_value(rd_entry.value);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = in_bad ? S_DONE : S_START;
				end
			end
			S_START: state_d = S_PROBE;
			S_PROBE: begin
				if (probe_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = idx_q;
		wr.en          = 1'b0;
		wr.addr        = chk_idx_s1;
		wr.entry.key   = key_q;
		wr.entry.value = val_q;
		case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_START: rd_en = 1'b1;
			S_PROBE: begin
				rd_en = 1'b1;
				wr.en = (req_q == REQ_INSERT) && (hit_empty || hit_match);
			end
			S_DONE:  s_tready = 1'b0;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q        <= req_t'(s_tuser);
					key_q        <= in_key;
					val_q        <= narrow_value(s_tdata[S_TDATA_W-1 -: IN_VALUE_W]);
					idx_q        <= in_home;
					cnt_q        <= '0;
					res_status_q <= ST_BADKEY;
					res_slot_q   <= '0;
					res_fval_q   <= '0;
				end
			end
			S_START: begin
				chk_idx_s1 <= idx_q;
				idx_q      <= next_slot(idx_q);
			end
			S_PROBE: begin
				chk_idx_s1 <= idx_q;
				idx_q      <= next_slot(idx_q);
				cnt_q      <= cnt_q + 1'b1;
				if (probe_done) begin
					res_status_q <= probe_status;
					res_slot_q   <= probe_slot;
					res_fval_q   <= probe_fval;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= M_TDATA_W'({res_fval_q, res_slot_q});
			m_tuser_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`LPHT_ASSERT(a_wr_only_probe, !wr.en || state_q == S_PROBE, "slot write outside probe")
	`LPHT_ASSERT(a_cnt_bound, state_q != S_PROBE || cnt_q < SLOT_W'(TABLE_SLOTS), "probe overrun")
	`LPHT_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accept left block idle")
	`LPHT_ASSERT(a_badkey_zero, !(m_tvalid && m_tuser == ST_BADKEY) || m_tdata == '0, "bad key data")

endmodule

/* rtl/lpht_store.sv */
// Slot memory with per-slot valid bits and a registered read port.
module lpht_store
	import lpht_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output entry_t            rd_entry,
	output logic              rd_valid,
	input  wr_req_t           wr
);

	entry_t                 mem [TABLE_SLOTS];
	entry_t                 rd_entry_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

/* tb/tb.sv */
// Testbench for linear_probe_hash_table_top: stream driver, stream monitor and table model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lpht_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 40;
	localparam int VAL_LO       = OUT_SLOT_W;
	localparam int PAD_LO       = OUT_SLOT_W + IN_VALUE_W;

	typedef enum logic [1:0] {
		Q_BEAT,
		Q_PHASE,
		Q_HOLD,
		Q_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t      kind;
		req_t            req;
		logic [63:0]     key;
		logic [31:0]     value;
		int              phase;
	} step_t;

	typedef struct {
		status_t               status;
		logic [OUT_SLOT_W-1:0] slot;
		logic [31:0]           value;
	} answer_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // key[63:0], value[95:64]
	logic                 s_tuser  = 1'b0; // req_type
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // slot[4:0], found_value[36:5], zeros
	logic [STATUS_W-1:0]  m_tuser;        // status

	logic        tbl_valid [TABLE_SLOTS];
	logic [63:0] tbl_key   [TABLE_SLOTS];
	logic [31:0] tbl_val   [TABLE_SLOTS];

	step_t       steps[$];
	answer_t     answers[$];
	logic [63:0] issued[$];

	int      errors       = 0;
	int      phase        = 0;
	int      hold_ticket  = 0;
	int      hold_seen    = 0;
	int      hold_left    = 0;
	int      quiet_cycles = 0;
	logic    all_answered = 1'b1;
	step_t   head;
	answer_t want;

	linear_probe_hash_table_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic probe_table(input req_t req, input logic [63:0] key_in,
			input logic [31:0] value);
		logic [63:0] key;
		logic [7:0]  first;
		int          n;
		int          j;
		answer_t     a;
		key      = key_in & ({64{1'b1}} << (8 * (8 - KEY_BYTES)));
		first    = key[63:56];
		a.status = ST_MISS;
		a.slot   = '0;
		a.value  = '0;
		if (first < CHAR_A || first > CHAR_Z) begin
			a.status = ST_BADKEY;
		end else begin
			for (n = 0; n < TABLE_SLOTS; n++) begin
				j = (int'(first - CHAR_A) + n) % TABLE_SLOTS;
				if (!tbl_valid[j]) begin
					if (req == REQ_INSERT) begin
						tbl_valid[j] = 1'b1;
						tbl_key[j]   = key;
						tbl_val[j]   = value;
						a.status     = ST_NEW;
						a.slot       = OUT_SLOT_W'(j);
						a.value      = value;
					end
					break;
				end
				if (tbl_key[j] == key) begin
					if (req == REQ_INSERT) begin
						tbl_val[j] = value;
						a.status   = ST_UPDATED;
					end else begin
						a.status = ST_FOUND;
					end
					a.slot  = OUT_SLOT_W'(j);
					a.value = tbl_val[j];
					break;
				end
			end
		end
		answers.insert(answers.size(), a);
	endtask

	task automatic add_beat(input req_t req, input logic [63:0] key, input logic [31:0] value);
		step_t s;
		s.kind  = Q_BEAT;
		s.req   = req;
		s.key   = key;
		s.value = value;
		s.phase = 0;
		steps.insert(steps.size(), s);
		if (req == REQ_INSERT && key[63:56] >= CHAR_A && key[63:56] <= CHAR_Z)
			issued.insert(issued.size(), key);
	endtask

	task automatic add_ctrl(input step_kind_t kind, input int p);
		step_t s;
		s.kind  = kind;
		s.req   = REQ_INSERT;
		s.key   = '0;
		s.value = '0;
		s.phase = p;
		steps.insert(steps.size(), s);
	endtask

	function automatic logic [63:0] fresh_key();
		logic [7:0]  first;
		logic [63:0] k;
		int          len;
		if ($urandom_range(0, 2) == 0)
			first = 8'(CHAR_Z - $urandom_range(0, 3));
		else
			first = 8'(CHAR_A + $urandom_range(0, 25));
		len = $urandom_range(1, 8);
		k   = {first, 24'($urandom), 32'($urandom)};
		if (len < 8)
			k = k & ~({64{1'b1}} >> (8 * len));
		return k;
	endfunction

	function automatic logic [7:0] bad_first();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255 - 26));
		if (c >= CHAR_A)
			c = c + 8'd26;
		return c;
	endfunction

	function automatic logic [63:0] known_key();
		return issued[$urandom_range(0, issued.size() - 1)];
	endfunction

	task automatic add_random();
		int          r;
		logic [63:0] k;
		r = $urandom_range(0, 99);
		if (issued.size() == 0 && r < 50)
			r = 50;
		if (r < 30) begin
			add_beat(REQ_SEARCH, known_key(), $urandom);
		end else if (r < 50) begin
			add_beat(REQ_INSERT, known_key(), $urandom);
		end else if (r < 57) begin
			add_beat(REQ_INSERT, fresh_key(), $urandom);
		end else if (r < 75) begin
			add_beat(REQ_SEARCH, fresh_key(), $urandom);
		end else if (r < 85) begin
			k = known_key();
			k[$urandom_range(0, 55)] ^= 1'b1;
			add_beat(REQ_SEARCH, k, $urandom);
		end else if (r < 93) begin
			add_beat(req_t'($urandom_range(0, 1)), {bad_first(), 24'($urandom), 32'($urandom)},
				$urandom);
		end else begin
			add_beat(req_t'($urandom_range(0, 1)), {32'($urandom), 32'($urandom)}, $urandom);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (steps.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				head = steps[0];
				case (head.kind)
				Q_PHASE: begin
					phase    <= head.phase;
					s_tvalid <= 1'b0;
					steps.delete(0);
				end
				Q_HOLD: begin
					hold_ticket <= hold_ticket + 1;
					s_tvalid    <= 1'b0;
					steps.delete(0);
				end
				Q_DRAIN: begin
					s_tvalid <= 1'b0;
					if (!s_tvalid && all_answered)
						steps.delete(0);
				end
				default: begin
					if ($urandom_range(0, 99) < ((phase == 0) ? 11 : (phase == 1) ? 74 : 0)) begin
						s_tvalid <= 1'b0;
					end else begin
						s_tvalid <= 1'b1;
						s_tdata  <= {head.value, head.key};
						s_tuser  <= head.req;
						steps.delete(0);
					end
				end
				endcase
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_ticket) begin
			hold_seen <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= ((phase == 0) ? 74 : (phase == 1) ? 11 : 0));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				probe_table(req_t'(s_tuser), s_tdata[63:0], s_tdata[95:64]);
			if (m_tvalid && m_tready) begin
				if (answers.size() == 0) begin
					$display("%0t: unexpected beat: status %0d slot %0d value %h", $time,
						m_tuser, m_tdata[OUT_SLOT_W-1:0], m_tdata[PAD_LO-1:VAL_LO]);
					errors++;
				end else begin
					want = answers.pop_front();
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
						errors++;
					end
					if (m_tdata[OUT_SLOT_W-1:0] !== want.slot) begin
						$display("%0t: slot expected %0d actual %0d", $time, want.slot,
							m_tdata[OUT_SLOT_W-1:0]);
						errors++;
					end
					if (m_tdata[PAD_LO-1:VAL_LO] !== want.value) begin
						$display("%0t: found_value expected %h actual %h", $time, want.value,
							m_tdata[PAD_LO-1:VAL_LO]);
						errors++;
					end
					if (m_tdata[M_TDATA_W-1:PAD_LO] !== '0) begin
						$display("%0t: tdata pad expected 0 actual %h", $time,
							m_tdata[M_TDATA_W-1:PAD_LO]);
						errors++;
					end
				end
			end
			all_answered <= (answers.size() == 0);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("linear_probe_hash_table_top: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int i;
		int p;
		for (i = 0; i < TABLE_SLOTS; i++)
			tbl_valid[i] = 1'b0;

		add_ctrl(Q_PHASE, 0);
		add_beat(REQ_SEARCH, {CHAR_A, 56'h0}, 32'h1234_5678);
		add_beat(REQ_INSERT, 64'h0, 32'h5a5a_5a5a);
		add_beat(REQ_INSERT, {CHAR_A - 8'd1, 56'hff_ffff_ffff_ffff}, 32'h0000_0001);
		add_beat(REQ_SEARCH, {CHAR_Z + 8'd1, 56'h0}, 32'h0);
		add_beat(REQ_INSERT, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
		add_beat(REQ_INSERT, {CHAR_A, 56'h0}, 32'h7fff_ffff);
		add_beat(REQ_INSERT, {CHAR_A, 8'h62, 48'h0}, 32'h8000_0000);
		add_beat(REQ_INSERT, {CHAR_A, 56'h0}, 32'hffff_ffff);
		add_beat(REQ_SEARCH, {CHAR_A, 8'h62, 48'h0}, 32'h0);
		add_beat(REQ_INSERT, {CHAR_Z, 56'h0}, 32'h0);
		add_beat(REQ_INSERT, {8{CHAR_Z}}, 32'h0000_0001);
		add_beat(REQ_SEARCH, {8{CHAR_Z}}, 32'hffff_ffff);
		add_beat(REQ_SEARCH, {CHAR_Z, 8'h71, 48'h0}, 32'h0);
		add_beat(REQ_SEARCH, {8'h80, 56'h0}, 32'h0);
		add_beat(REQ_INSERT, {8'h6d, 56'hff_ffff_ffff_ffff}, 32'hdead_beef);
		add_beat(REQ_SEARCH, {8'h6d, 56'hff_ffff_ffff_ffff}, 32'h0);
		add_beat(REQ_INSERT, {CHAR_A, 56'h0}, 32'h0);
		add_beat(REQ_SEARCH, {CHAR_A, 56'h0}, 32'hdead_beef);
		add_ctrl(Q_DRAIN, 0);

		for (p = 0; p < 3; p++) begin
			add_ctrl(Q_PHASE, p);
			for (i = 0; i < RANDOM_ITEMS / 3; i++) begin
				if (i == 40)
					add_ctrl(Q_HOLD, 0);
				if (i == 90)
					add_ctrl(Q_DRAIN, 0);
				add_random();
			end
			add_ctrl(Q_DRAIN, 0);
		end

		// fill the table, then run full-wrap insert and search
		for (i = 0; i < TABLE_SLOTS + 2; i++)
			add_beat(REQ_INSERT, fresh_key(), $urandom);
		add_beat(REQ_SEARCH, fresh_key(), $urandom);
		add_beat(REQ_SEARCH, {CHAR_Z, 8'h00, 48'h1}, $urandom);
		add_beat(REQ_INSERT, known_key(), $urandom);
		add_beat(REQ_SEARCH, known_key(), $urandom);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (steps.size() != 0 || s_tvalid || answers.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("linear_probe_hash_table_top: match");
		else
			$display("linear_probe_hash_table_top: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_store.sv
rtl/linear_probe_hash_table_top.sv
tb/tb.sv
